// File: rtl/core/brom_pkg.sv
// Shared types, constants and the arctangent table for the range-bearing
// observation model. No dependencies.
`timescale 1ns / 1ps

package brom_pkg;

   // CORDIC depth; stages beyond 32 add nothing
   localparam int CORDIC_ITERATIONS = 16;
   localparam int CORDIC_STAGES = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;

   localparam int XY_W  = 60;   // scaled CORDIC vector width
   localparam int Z_W   = 34;   // Q2.30 angle accumulator with headroom
   localparam int RNG_W = 33;   // range and divisor width
   localparam int DIV_W = 32;   // quotient bits produced per divider chain

   localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;
   localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
   localparam logic signed [17:0] BEARING_MAX = 18'sd25735;
   localparam logic signed [17:0] BEARING_MIN = -18'sd25736;
   localparam logic [RNG_W-1:0] RANGE_MAX = 33'h1_FFFF_FFFF;
   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
   localparam logic [31:0] LIM_Q31 = 32'h8000_0000;

   typedef struct packed {
      logic signed [31:0] robot_x;
      logic signed [31:0] robot_y;
      logic signed [15:0] robot_heading;
      logic signed [31:0] landmark_x;
      logic signed [31:0] landmark_y;
   } req_item_type;

   typedef struct packed {
      logic [32:0]        expected_range;
      logic signed [15:0] expected_bearing;
      logic signed [31:0] dx_over_range;
      logic signed [31:0] dy_over_range;
      logic signed [31:0] dy_over_squared;
      logic signed [31:0] dx_over_squared;
      logic               zero_distance;
      logic               saturated;
   } rsp_item_type;

   // item context that travels alongside the datapath
   typedef struct packed {
      logic               valid;
      logic               zero;
      logic               sx;
      logic               sy;
      logic [32:0]        ax;
      logic [32:0]        ay;
      logic signed [15:0] bearing;
      logic [RNG_W-1:0]   range;
      logic [RNG_W-1:0]   rr;
      logic signed [31:0] dxr;
      logic signed [31:0] dyr;
      logic               sat;
      logic               ovf_x;
      logic               ovf_y;
   } side_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } vec_type;

   // one divider lane: partial remainder and numerator/quotient shift word
   typedef struct packed {
      logic [RNG_W-1:0] rem;
      logic [DIV_W-1:0] num;
   } lane_type;

   // atan(2^-i) in Q2.30, truncated
   function automatic logic [31:0] atan_q30(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/core/brom_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its output register.
// Depends on brom_pkg.
`timescale 1ns / 1ps

module brom_cordic_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic [4:0]         idx,
   input  brom_pkg::side_type prev_side,
   input  brom_pkg::vec_type  prev_vec,
   output brom_pkg::side_type next_side,
   output brom_pkg::vec_type  next_vec
);

   brom_pkg::vec_type  vec_ff, vec_in;
   brom_pkg::side_type side_ff;
   logic signed [brom_pkg::XY_W-1:0] xs, ys;
   logic signed [brom_pkg::Z_W-1:0]  az;

   // rotate toward the x axis; shifts floor toward minus infinity
   always_comb begin
      xs = prev_vec.x >>> idx;
      ys = prev_vec.y >>> idx;
      az = signed'({2'b00, brom_pkg::atan_q30(idx)});
      if (!prev_vec.y[brom_pkg::XY_W-1]) begin
         vec_in.x = prev_vec.x + ys;
         vec_in.y = prev_vec.y - xs;
         vec_in.z = prev_vec.z + az;
      end else begin
         vec_in.x = prev_vec.x - ys;
         vec_in.y = prev_vec.y + xs;
         vec_in.z = prev_vec.z - az;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (en) begin
         side_ff <= prev_side;
         vec_ff  <= vec_in;
      end
   end

   assign next_side = side_ff;
   assign next_vec  = vec_ff;

endmodule

// File: rtl/core/brom_div_cell.sv
// One restoring-division step for the x and y lanes, divisor from the item
// context. Depends on brom_pkg.
`timescale 1ns / 1ps

module brom_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  brom_pkg::side_type prev_side,
   input  brom_pkg::lane_type prev_lane [2],
   output brom_pkg::side_type next_side,
   output brom_pkg::lane_type next_lane [2]
);

   brom_pkg::side_type side_ff;
   brom_pkg::lane_type lane_ff [2];
   brom_pkg::lane_type lane_in [2];
   logic [brom_pkg::RNG_W:0] trial [2];
   logic                     ge [2];

   // bring down one numerator bit, subtract divisor if it fits
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         trial[k] = {prev_lane[k].rem, prev_lane[k].num[brom_pkg::DIV_W-1]};
         ge[k]    = trial[k] >= {1'b0, prev_side.rr};
         lane_in[k].rem = ge[k] ? brom_pkg::RNG_W'(trial[k] - {1'b0, prev_side.rr})
                                : trial[k][brom_pkg::RNG_W-1:0];
         lane_in[k].num = {prev_lane[k].num[brom_pkg::DIV_W-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (en) begin
         side_ff    <= prev_side;
         lane_ff[0] <= lane_in[0];
         lane_ff[1] <= lane_in[1];
      end
   end

   assign next_side = side_ff;
   assign next_lane = lane_ff;

endmodule

// File: rtl/core/range_bearing_observation_model_top.sv
// Range-bearing observation model top level: front end, CORDIC cell chain,
// gain multiply, two divider cell chains and output register. Depends on
// brom_pkg, brom_cordic_cell and brom_div_cell.
`timescale 1ns / 1ps

// One item enters per clock while the pipeline is not held, and each passes
// through an input register, one cell per CORDIC rotation, the registers for
// the gain multiply, range and dividend setup, 32 divider cells for dx/r and
// dy/r, a setup register, 32 divider cells for dx/q and dy/q, and the output
// register. The whole pipeline holds while a result waits at rsp_valid with
// rsp_ready low.
module range_bearing_observation_model_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  brom_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output brom_pkg::rsp_item_type rsp_item
);

   localparam int NS = brom_pkg::CORDIC_STAGES;

   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // ---------------- front end: differences and pre-rotation
   logic signed [32:0] dx, dy, x0, y0;
   brom_pkg::side_type side0_in;
   brom_pkg::vec_type  vec0_in;

   always_comb begin
      dx = {req_item.landmark_x[31], req_item.landmark_x}
         - {req_item.robot_x[31], req_item.robot_x};
      dy = {req_item.landmark_y[31], req_item.landmark_y}
         - {req_item.robot_y[31], req_item.robot_y};
      side0_in       = '0;
      side0_in.valid = req_valid;
      side0_in.zero  = (dx == '0) && (dy == '0);
      side0_in.sx    = dx[32];
      side0_in.sy    = dy[32];
      side0_in.ax    = dx[32] ? 33'(-dx) : 33'(dx);
      side0_in.ay    = dy[32] ? 33'(-dy) : 33'(dy);
      side0_in.bearing = req_item.robot_heading;
      vec0_in.z = '0;
      if (dx[32] && !dy[32]) begin
         x0 = dy;
         y0 = -dx;
         vec0_in.z = brom_pkg::HALF_PI_Q30;
      end else if (dx[32]) begin
         x0 = -dy;
         y0 = dx;
         vec0_in.z = -brom_pkg::HALF_PI_Q30;
      end else begin
         x0 = dx;
         y0 = dy;
      end
      vec0_in.x = {{(brom_pkg::XY_W-57){x0[32]}}, x0, 24'b0};
      vec0_in.y = {{(brom_pkg::XY_W-57){y0[32]}}, y0, 24'b0};
   end

   brom_pkg::side_type side_pipe [NS+1];
   brom_pkg::vec_type  vec_pipe  [NS+1];
   brom_pkg::side_type side0_ff;
   brom_pkg::vec_type  vec0_ff;

   // heading rides in the bearing field until the angle is known
   always_ff @(posedge clock) begin
      if (reset) begin
         side0_ff.valid <= 1'b0;
      end else if (en) begin
         side0_ff <= side0_in;
         vec0_ff  <= vec0_in;
      end
   end

   assign side_pipe[0] = side0_ff;
   assign vec_pipe[0]  = vec0_ff;

   // ---------------- CORDIC cell chain
   for (genvar i = 0; i < NS; i++) begin : g_cordic
      brom_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .idx       (5'(i)),
         .prev_side (side_pipe[i]),
         .prev_vec  (vec_pipe[i]),
         .next_side (side_pipe[i+1]),
         .next_vec  (vec_pipe[i+1])
      );
   end

   // ---------------- gain multiply halves and bearing wrap
   brom_pkg::side_type m1_ff, m1_in;
   logic [59:0] phi_ff, phi_in;
   logic [63:0] plo_ff, plo_in;
   logic signed [brom_pkg::Z_W-1:0] zr;
   logic signed [16:0] ang13;
   logic signed [17:0] bdiff;

   always_comb begin
      m1_in  = side_pipe[NS];
      phi_in = vec_pipe[NS].x[59:32] * brom_pkg::INV_GAIN_Q32;
      plo_in = vec_pipe[NS].x[31:0] * brom_pkg::INV_GAIN_Q32;
      zr     = (vec_pipe[NS].z + 34'sd65536) >>> 17;
      ang13  = side_pipe[NS].zero ? 17'sd0 : zr[16:0];
      bdiff  = 18'(ang13) - 18'(side_pipe[NS].bearing);
      if (bdiff > brom_pkg::BEARING_MAX) begin
         bdiff = bdiff - brom_pkg::TWO_PI_Q13;
      end else if (bdiff < brom_pkg::BEARING_MIN) begin
         bdiff = bdiff + brom_pkg::TWO_PI_Q13;
      end
      m1_in.bearing = bdiff[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ff.valid <= 1'b0;
      end else if (en) begin
         m1_ff  <= m1_in;
         phi_ff <= phi_in;
         plo_ff <= plo_in;
      end
   end

   // ---------------- range: sum, round off guard bits, saturate
   brom_pkg::side_type m2_ff, m2_in;
   logic [60:0] tsum;
   logic [36:0] rfull;

   always_comb begin
      m2_in = m1_ff;
      tsum  = {1'b0, phi_ff} + {29'b0, plo_ff[63:32]};
      rfull = 37'((tsum + 61'd8388608) >> 24);
      m2_in.range = (rfull > {4'b0, brom_pkg::RANGE_MAX}) ? brom_pkg::RANGE_MAX
                                                        : rfull[32:0];
      m2_in.rr = (m2_in.range == '0) ? 33'd1 : m2_in.range;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_ff.valid <= 1'b0;
      end else if (en) begin
         m2_ff <= m2_in;
      end
   end

   // ---------------- first dividend: |d| * 2^30 + r/2
   brom_pkg::side_type m3_ff, m3_in;
   brom_pkg::lane_type l3_ff [2];
   brom_pkg::lane_type l3_in [2];
   logic [63:0] n1 [2];
   logic        o1 [2];

   always_comb begin
      m3_in = m2_ff;
      n1[0] = {m2_ff.ax[32:0], 30'b0} + {32'b0, m2_ff.rr[32:1]};
      n1[1] = {m2_ff.ay[32:0], 30'b0} + {32'b0, m2_ff.rr[32:1]};
      for (int k = 0; k < 2; k++) begin
         o1[k] = {1'b0, n1[k][63:32]} >= m2_ff.rr;
         l3_in[k].rem = o1[k] ? '0 : {1'b0, n1[k][63:32]};
         l3_in[k].num = n1[k][31:0];
      end
      m3_in.ovf_x = o1[0];
      m3_in.ovf_y = o1[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_ff.valid <= 1'b0;
      end else if (en) begin
         m3_ff    <= m3_in;
         l3_ff[0] <= l3_in[0];
         l3_ff[1] <= l3_in[1];
      end
   end

   // ---------------- divider chain for dx/r, dy/r
   brom_pkg::side_type d1_side [brom_pkg::DIV_W+1];
   brom_pkg::lane_type d1_lane [brom_pkg::DIV_W+1][2];

   assign d1_side[0] = m3_ff;
   assign d1_lane[0] = l3_ff;

   for (genvar i = 0; i < brom_pkg::DIV_W; i++) begin : g_div1
      brom_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .prev_side (d1_side[i]),
         .prev_lane (d1_lane[i]),
         .next_side (d1_side[i+1]),
         .next_lane (d1_lane[i+1])
      );
   end

   // ---------------- clamp first quotients, second dividend 4*q + r/2
   brom_pkg::side_type md_ff, md_in;
   brom_pkg::lane_type ld_ff [2];
   brom_pkg::lane_type ld_in [2];
   logic [31:0] q1 [2];
   logic        big1 [2];
   logic        s1 [2];
   logic [31:0] m1v [2];
   logic [31:0] c1 [2];
   logic [34:0] n2 [2];
   logic        o2 [2];
   logic signed [31:0] r1 [2];

   always_comb begin
      md_in   = d1_side[brom_pkg::DIV_W];
      big1[0] = d1_side[brom_pkg::DIV_W].ovf_x;
      big1[1] = d1_side[brom_pkg::DIV_W].ovf_y;
      s1[0]   = d1_side[brom_pkg::DIV_W].sx;
      s1[1]   = d1_side[brom_pkg::DIV_W].sy;
      md_in.sat = 1'b0;
      for (int k = 0; k < 2; k++) begin
         q1[k]  = d1_lane[brom_pkg::DIV_W][k].num;
         m1v[k] = (big1[k] || q1[k] > brom_pkg::ONE_Q30) ? brom_pkg::ONE_Q30 : q1[k];
         if (big1[k] || q1[k] > brom_pkg::ONE_Q30) begin
            md_in.sat = 1'b1;
         end
         r1[k] = s1[k] ? -signed'(m1v[k]) : signed'(m1v[k]);
         c1[k] = (big1[k] || q1[k] > brom_pkg::LIM_Q31) ? brom_pkg::LIM_Q31 : q1[k];
         n2[k] = {1'b0, c1[k], 2'b00} + {3'b0, md_in.rr[32:1]};
         o2[k] = {30'b0, n2[k][34:32]} >= md_in.rr;
         ld_in[k].rem = o2[k] ? '0 : {30'b0, n2[k][34:32]};
         ld_in[k].num = n2[k][31:0];
      end
      md_in.dxr   = r1[0];
      md_in.dyr   = r1[1];
      md_in.ovf_x = o2[0];
      md_in.ovf_y = o2[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         md_ff.valid <= 1'b0;
      end else if (en) begin
         md_ff    <= md_in;
         ld_ff[0] <= ld_in[0];
         ld_ff[1] <= ld_in[1];
      end
   end

   // ---------------- divider chain for dx/q, dy/q
   brom_pkg::side_type d2_side [brom_pkg::DIV_W+1];
   brom_pkg::lane_type d2_lane [brom_pkg::DIV_W+1][2];

   assign d2_side[0] = md_ff;
   assign d2_lane[0] = ld_ff;

   for (genvar i = 0; i < brom_pkg::DIV_W; i++) begin : g_div2
      brom_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .prev_side (d2_side[i]),
         .prev_lane (d2_lane[i]),
         .next_side (d2_side[i+1]),
         .next_lane (d2_lane[i+1])
      );
   end

   // ---------------- final clamp and output register
   brom_pkg::side_type fs;
   brom_pkg::rsp_item_type rsp_ff, rsp_in;
   logic rsp_valid_ff;
   logic [31:0] q2 [2];
   logic        big2 [2];
   logic        s2 [2];
   logic [31:0] m2v [2];
   logic        sat2 [2];
   logic signed [31:0] r2 [2];

   always_comb begin
      fs      = d2_side[brom_pkg::DIV_W];
      big2[0] = fs.ovf_x;
      big2[1] = fs.ovf_y;
      s2[0]   = fs.sx;
      s2[1]   = fs.sy;
      for (int k = 0; k < 2; k++) begin
         q2[k] = d2_lane[brom_pkg::DIV_W][k].num;
         if (s2[k]) begin
            sat2[k] = big2[k] || q2[k] > brom_pkg::LIM_Q31;
            m2v[k]  = sat2[k] ? brom_pkg::LIM_Q31 : q2[k];
            r2[k]   = -signed'(m2v[k]);
         end else begin
            sat2[k] = big2[k] || q2[k] > (brom_pkg::LIM_Q31 - 32'd1);
            m2v[k]  = sat2[k] ? (brom_pkg::LIM_Q31 - 32'd1) : q2[k];
            r2[k]   = signed'(m2v[k]);
         end
      end
      rsp_in.expected_range   = fs.zero ? '0 : fs.range;
      rsp_in.expected_bearing = fs.bearing;
      rsp_in.dx_over_range    = fs.zero ? '0 : fs.dxr;
      rsp_in.dy_over_range    = fs.zero ? '0 : fs.dyr;
      rsp_in.dx_over_squared  = fs.zero ? '0 : r2[0];
      rsp_in.dy_over_squared  = fs.zero ? '0 : r2[1];
      rsp_in.zero_distance    = fs.zero;
      rsp_in.saturated        = !fs.zero && (fs.sat || sat2[0] || sat2[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= fs.valid;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTH
   // coincident points give an all-zero Jacobian and range
   a_zero_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.zero_distance |->
         rsp_item.expected_range == '0 && rsp_item.dx_over_range == '0 &&
         rsp_item.dy_over_range == '0 && rsp_item.dx_over_squared == '0 &&
         rsp_item.dy_over_squared == '0 && !rsp_item.saturated)
      else $error("zero-distance item has nonzero outputs");

   // bearing wrap lands in [-pi, pi)
   a_bearing_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.expected_bearing <= 16'sd25735 &&
                    rsp_item.expected_bearing >= -16'sd25736)
      else $error("bearing outside wrap interval");

   // unit-vector terms never exceed one
   a_unit_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.dx_over_range <= 32'sh4000_0000 &&
                    rsp_item.dx_over_range >= -32'sh4000_0000 &&
                    rsp_item.dy_over_range <= 32'sh4000_0000 &&
                    rsp_item.dy_over_range >= -32'sh4000_0000)
      else $error("dx/r or dy/r beyond one");

   // a held result freezes the whole pipeline, input side included
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while output stalled");
`endif

endmodule
